// File: hdl/blpg_pkg.sv
// ----------------------------------------------------------------------------
// blpg_pkg: shared definitions for the Bresenham line pixel generator
// Field widths, register map, reset values and the control structs that
// join the controller, the datapath and the register file.
// ----------------------------------------------------------------------------
package blpg_pkg;

   localparam int COORD_BITS    = 12;
   localparam int DIM_BITS      = 12;
   localparam int STRIDE_BITS   = 14;
   localparam int BPP_BITS      = 3;
   localparam int OFFSET_BITS   = 25;
   localparam int COLOR_BITS    = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DIM_BITS-1:0]    FRAME_WIDTH_RESET     = 12'd1024;
   localparam logic [DIM_BITS-1:0]    FRAME_HEIGHT_RESET    = 12'd768;
   localparam logic [STRIDE_BITS-1:0] LINE_STRIDE_RESET     = 14'd4096;
   localparam logic [BPP_BITS-1:0]    BYTES_PER_PIXEL_RESET = 3'd4;

   // Register index, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_FRAME_WIDTH     = 2'd0,
      REG_FRAME_HEIGHT    = 2'd1,
      REG_LINE_STRIDE     = 2'd2,
      REG_BYTES_PER_PIXEL = 2'd3
   } csr_reg_type;

   // Input item kind, carried in req_tuser.
   typedef enum logic {
      MODE_START = 1'b0,
      MODE_STEP  = 1'b1
   } mode_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]    frame_width;
      logic [DIM_BITS-1:0]    frame_height;
      logic [STRIDE_BITS-1:0] line_stride;
      logic [BPP_BITS-1:0]    bytes_per_pixel;
   } cfg_type;

   typedef struct packed {
      logic load_line;  // latch endpoints and set up the error term
      logic issue;      // emit the next pixel into the multiply stage
      logic load_out;   // move the multiply stage into the output register
   } cmd_type;

   typedef struct packed {
      logic steps_zero; // the next pixel is the endpoint
   } status_type;

endpackage

// File: hdl/bresenham_line_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator_unit: Bresenham line rasterizer
// Steps along one line per start beat and gives one clipped, addressed pixel
// for each step beat of an active line.
// ----------------------------------------------------------------------------
// Usage. The req channel carries the kind of beat in req_tuser: a start beat
// latches both endpoints and the color and produces no output; each step
// beat produces the next pixel of the active line on the rsp channel. The
// endpoint pixel comes with rsp_tlast set, and the line then goes idle, so
// further step beats are absorbed without output until the next start beat.
// A start beat during a line abandons it.
// One beat is taken per cycle while req_tready is high. A pixel passes
// through the multiply stage, which forms y*line_stride and x*bytes_per_pixel,
// and then the output register, where the offset is summed, before it appears
// on rsp. The two stages act as a skid, so req_tready only drops when both
// are full and rsp_tready is low; a stall downstream never loses or repeats a
// pixel.
// Reset (synchronous, active high) drops any line, empties both stages and
// loads the frame registers with 1024 x 768, stride 4096, 4 bytes per pixel.
// The csr port must be written only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_unit #(
   parameter int COORD_BITS = blpg_pkg::COORD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata, low bit up: start_x, start_y, end_x, end_y, color
   input  logic [((4*COORD_BITS+blpg_pkg::COLOR_BITS+7)/8)*8-1:0] req_tdata,
   // req_tuser: mode
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata, low bit up: pixel_x, pixel_y, in_frame, byte_offset,
   // pixel_color
   output logic [((2*COORD_BITS+blpg_pkg::OFFSET_BITS+blpg_pkg::COLOR_BITS+8)/8)*8-1:0]
                                               rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [blpg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [blpg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [blpg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int C     = COORD_BITS;
   localparam int KW    = blpg_pkg::COLOR_BITS;
   localparam int OW    = blpg_pkg::OFFSET_BITS;
   localparam int RSP_W = ((2*C + OW + KW + 8) / 8) * 8;

   blpg_pkg::cfg_type    cfg;
   blpg_pkg::cmd_type    cmd;
   blpg_pkg::status_type status;

   logic [C-1:0]  pixel_x, pixel_y;
   logic          in_frame;
   logic [OW-1:0] byte_offset;
   logic [KW-1:0] pixel_color;

   assign csr_pready = 1'b1;

   blpg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   blpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   blpg_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .cfg         (cfg),
      .start_x     (req_tdata[C-1:0]),
      .start_y     (req_tdata[2*C-1:C]),
      .end_x       (req_tdata[3*C-1:2*C]),
      .end_y       (req_tdata[4*C-1:3*C]),
      .color       (req_tdata[4*C+KW-1:4*C]),
      .status      (status),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .in_frame    (in_frame),
      .byte_offset (byte_offset),
      .pixel_color (pixel_color),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({pixel_color, byte_offset, in_frame, pixel_y, pixel_x});

endmodule

// File: hdl/blpg_csr.sv
// ----------------------------------------------------------------------------
// blpg_csr: configuration register file
// Holds frame size, row stride and pixel size behind an APB-style port.
// ----------------------------------------------------------------------------
module blpg_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [blpg_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [blpg_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [blpg_pkg::CSR_DATA_BITS-1:0]     prdata,
   output blpg_pkg::cfg_type                      cfg
);

   localparam int DW = blpg_pkg::CSR_DATA_BITS;

   blpg_pkg::cfg_type     cfg_ff;
   blpg_pkg::cfg_type     cfg_in;
   blpg_pkg::csr_reg_type reg_sel;
   logic                  write_en;

   assign reg_sel  = blpg_pkg::csr_reg_type'(paddr[3:2]);
   assign write_en = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_sel)
            blpg_pkg::REG_FRAME_WIDTH:
               cfg_in.frame_width = pwdata[blpg_pkg::DIM_BITS-1:0];
            blpg_pkg::REG_FRAME_HEIGHT:
               cfg_in.frame_height = pwdata[blpg_pkg::DIM_BITS-1:0];
            blpg_pkg::REG_LINE_STRIDE:
               cfg_in.line_stride = pwdata[blpg_pkg::STRIDE_BITS-1:0];
            blpg_pkg::REG_BYTES_PER_PIXEL:
               cfg_in.bytes_per_pixel = pwdata[blpg_pkg::BPP_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         blpg_pkg::REG_FRAME_WIDTH:     prdata = DW'(cfg_ff.frame_width);
         blpg_pkg::REG_FRAME_HEIGHT:    prdata = DW'(cfg_ff.frame_height);
         blpg_pkg::REG_LINE_STRIDE:     prdata = DW'(cfg_ff.line_stride);
         blpg_pkg::REG_BYTES_PER_PIXEL: prdata = DW'(cfg_ff.bytes_per_pixel);
         default:                       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width     <= blpg_pkg::FRAME_WIDTH_RESET;
         cfg_ff.frame_height    <= blpg_pkg::FRAME_HEIGHT_RESET;
         cfg_ff.line_stride     <= blpg_pkg::LINE_STRIDE_RESET;
         cfg_ff.bytes_per_pixel <= blpg_pkg::BYTES_PER_PIXEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/blpg_datapath.sv
// ----------------------------------------------------------------------------
// blpg_datapath: line stepping and address datapath
// Keeps the line's error term and current point, computes clip flag and
// address products in a multiply stage and the final offset in the output
// register.
// ----------------------------------------------------------------------------
module blpg_datapath #(
   parameter int COORD_BITS = blpg_pkg::COORD_BITS
) (
   input  logic                                 clock,
   input  blpg_pkg::cmd_type                    cmd,
   input  blpg_pkg::cfg_type                    cfg,
   input  logic [COORD_BITS-1:0]                start_x,
   input  logic [COORD_BITS-1:0]                start_y,
   input  logic [COORD_BITS-1:0]                end_x,
   input  logic [COORD_BITS-1:0]                end_y,
   input  logic [blpg_pkg::COLOR_BITS-1:0]      color,
   output blpg_pkg::status_type                 status,
   output logic [COORD_BITS-1:0]                pixel_x,
   output logic [COORD_BITS-1:0]                pixel_y,
   output logic                                 in_frame,
   output logic [blpg_pkg::OFFSET_BITS-1:0]     byte_offset,
   output logic [blpg_pkg::COLOR_BITS-1:0]      pixel_color,
   output logic                                 last
);

   localparam int C   = COORD_BITS;
   localparam int EW  = C + 2;
   localparam int SW  = C + 3;
   localparam int DW  = blpg_pkg::DIM_BITS;
   localparam int CW  = (C > DW) ? C : DW;
   localparam int PW  = C + blpg_pkg::STRIDE_BITS;
   localparam int XPW = C + blpg_pkg::BPP_BITS;
   localparam int OW  = blpg_pkg::OFFSET_BITS;
   localparam int KW  = blpg_pkg::COLOR_BITS;

   // Line state.
   logic [C-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [C-1:0]  final_x_ff, final_x_in, final_y_ff, final_y_in;
   logic [EW-1:0] err_ff, err_in;
   logic [C-1:0]  major_ff, major_in, minor_ff, minor_in;
   logic [1:0]    dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic          swap_ff, swap_in;
   logic [C-1:0]  steps_ff, steps_in;
   logic [KW-1:0] color_ff, color_in;

   // Multiply stage.
   logic [C-1:0]   a_x_ff, a_x_in, a_y_ff, a_y_in;
   logic           a_inside_ff, a_inside_in, a_last_ff, a_last_in;
   logic [KW-1:0]  a_color_ff, a_color_in;
   logic [PW-1:0]  a_prody_ff, a_prody_in;
   logic [XPW-1:0] a_prodx_ff, a_prodx_in;

   // Output register.
   logic [C-1:0]  o_x_ff, o_x_in, o_y_ff, o_y_in;
   logic          o_inside_ff, o_inside_in, o_last_ff, o_last_in;
   logic [OW-1:0] o_offset_ff, o_offset_in;
   logic [KW-1:0] o_color_ff, o_color_in;

   // Setup terms for a new line.
   logic [C:0]    diff_x, diff_y;
   logic [C-1:0]  abs_x, abs_y, init_major, init_minor;
   logic          init_swap;

   // Stepping terms.
   logic          steps_zero, err_ge0, x_inc, y_inc;
   logic [SW-1:0] err_ext, err_adj, err_sum;
   logic [C-1:0]  sel_x, sel_y;

   assign diff_x = {end_x[C-1], end_x} - {start_x[C-1], start_x};
   assign diff_y = {end_y[C-1], end_y} - {start_y[C-1], start_y};
   assign abs_x  = diff_x[C] ? C'(-diff_x) : diff_x[C-1:0];
   assign abs_y  = diff_y[C] ? C'(-diff_y) : diff_y[C-1:0];
   assign init_swap  = abs_y > abs_x;
   assign init_major = init_swap ? abs_y : abs_x;
   assign init_minor = init_swap ? abs_x : abs_y;

   assign steps_zero = (steps_ff == '0);
   assign err_ge0    = ~err_ff[EW-1];
   assign err_ext    = {err_ff[EW-1], err_ff};
   assign err_adj    = err_ge0 ? (err_ext - {2'b00, major_ff, 1'b0}) : err_ext;
   assign err_sum    = err_adj + {2'b00, minor_ff, 1'b0};
   // The major axis moves every step; the minor axis only when the error
   // term has reached zero.
   assign x_inc      = swap_ff ? err_ge0 : 1'b1;
   assign y_inc      = swap_ff ? 1'b1 : err_ge0;

   assign sel_x = steps_zero ? final_x_ff : cur_x_ff;
   assign sel_y = steps_zero ? final_y_ff : cur_y_ff;

   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      final_x_in = final_x_ff;
      final_y_in = final_y_ff;
      err_in     = err_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      dir_x_in   = dir_x_ff;
      dir_y_in   = dir_y_ff;
      swap_in    = swap_ff;
      steps_in   = steps_ff;
      color_in   = color_ff;
      if (cmd.load_line) begin
         cur_x_in   = start_x;
         cur_y_in   = start_y;
         final_x_in = end_x;
         final_y_in = end_y;
         dir_x_in   = diff_x[C] ? 2'b11 : ((diff_x != '0) ? 2'b01 : 2'b00);
         dir_y_in   = diff_y[C] ? 2'b11 : ((diff_y != '0) ? 2'b01 : 2'b00);
         swap_in    = init_swap;
         major_in   = init_major;
         minor_in   = init_minor;
         err_in     = {1'b0, init_minor, 1'b0} - {2'b00, init_major};
         steps_in   = init_major;
         color_in   = color;
      end else if (cmd.issue && !steps_zero) begin
         err_in   = err_sum[EW-1:0];
         steps_in = steps_ff - 1'b1;
         if (x_inc) begin
            cur_x_in = cur_x_ff + {{(C-2){dir_x_ff[1]}}, dir_x_ff};
         end
         if (y_inc) begin
            cur_y_in = cur_y_ff + {{(C-2){dir_y_ff[1]}}, dir_y_ff};
         end
      end
   end

   always_comb begin
      a_x_in      = a_x_ff;
      a_y_in      = a_y_ff;
      a_inside_in = a_inside_ff;
      a_last_in   = a_last_ff;
      a_color_in  = a_color_ff;
      a_prody_in  = a_prody_ff;
      a_prodx_in  = a_prodx_ff;
      if (cmd.issue) begin
         a_x_in      = sel_x;
         a_y_in      = sel_y;
         a_last_in   = steps_zero;
         a_color_in  = color_ff;
         a_inside_in = ~sel_x[C-1] && ~sel_y[C-1] &&
                       (CW'(sel_x) < CW'(cfg.frame_width)) &&
                       (CW'(sel_y) < CW'(cfg.frame_height));
         a_prody_in  = PW'(sel_y) * PW'(cfg.line_stride);
         a_prodx_in  = XPW'(sel_x) * XPW'(cfg.bytes_per_pixel);
      end
   end

   always_comb begin
      o_x_in      = o_x_ff;
      o_y_in      = o_y_ff;
      o_inside_in = o_inside_ff;
      o_last_in   = o_last_ff;
      o_color_in  = o_color_ff;
      o_offset_in = o_offset_ff;
      if (cmd.load_out) begin
         o_x_in      = a_x_ff;
         o_y_in      = a_y_ff;
         o_inside_in = a_inside_ff;
         o_last_in   = a_last_ff;
         o_color_in  = a_color_ff;
         o_offset_in = a_inside_ff ? (OW'(a_prody_ff) + OW'(a_prodx_ff)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      final_x_ff  <= final_x_in;
      final_y_ff  <= final_y_in;
      err_ff      <= err_in;
      major_ff    <= major_in;
      minor_ff    <= minor_in;
      dir_x_ff    <= dir_x_in;
      dir_y_ff    <= dir_y_in;
      swap_ff     <= swap_in;
      steps_ff    <= steps_in;
      color_ff    <= color_in;
      a_x_ff      <= a_x_in;
      a_y_ff      <= a_y_in;
      a_inside_ff <= a_inside_in;
      a_last_ff   <= a_last_in;
      a_color_ff  <= a_color_in;
      a_prody_ff  <= a_prody_in;
      a_prodx_ff  <= a_prodx_in;
      o_x_ff      <= o_x_in;
      o_y_ff      <= o_y_in;
      o_inside_ff <= o_inside_in;
      o_last_ff   <= o_last_in;
      o_color_ff  <= o_color_in;
      o_offset_ff <= o_offset_in;
   end

   assign status.steps_zero = steps_zero;
   assign pixel_x     = o_x_ff;
   assign pixel_y     = o_y_ff;
   assign in_frame    = o_inside_ff;
   assign byte_offset = o_offset_ff;
   assign pixel_color = o_color_ff;
   assign last        = o_last_ff;

endmodule

// File: hdl/blpg_ctrl.sv
// ----------------------------------------------------------------------------
// blpg_ctrl: line controller
// Tracks whether a line is being drawn, decodes input beats into datapath
// commands and keeps the valid bits of the multiply stage and output register.
// ----------------------------------------------------------------------------
module blpg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_mode,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  blpg_pkg::status_type  status,
   output blpg_pkg::cmd_type     cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_DRAW
   } state_type;

   state_type state_ff, state_in;
   logic      a_valid_ff, a_valid_in;
   logic      out_valid_ff, out_valid_in;
   logic      accept, is_start, issue, load_out;

   assign load_out   = a_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || load_out;
   assign accept     = req_tvalid && req_tready;
   assign is_start   = (blpg_pkg::mode_type'(req_mode) == blpg_pkg::MODE_START);
   assign issue      = accept && !is_start && (state_ff == ST_DRAW);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_start) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (issue && status.steps_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      a_valid_in = a_valid_ff;
      if (issue) begin
         a_valid_in = 1'b1;
      end else if (load_out) begin
         a_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign cmd.load_line = accept && is_start;
   assign cmd.issue     = issue;
   assign cmd.load_out  = load_out;
   assign rsp_tvalid    = out_valid_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while both pixel stages are full and stalled");

   a_endpoint_ends_line: assert property (@(posedge clock) disable iff (reset)
      (issue && status.steps_zero) |=> (state_ff == ST_IDLE))
      else $error("line still active after its endpoint pixel");

   a_issue_fills_stage: assert property (@(posedge clock) disable iff (reset)
      issue |=> a_valid_ff)
      else $error("issued pixel lost from the multiply stage");

endmodule

// File: sim/blpg_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blpg_pixel_checker: pixel scoreboard for the line pixel generator
// Watches the req, rsp and csr ports, updates its own copy of the line state
// for every accepted req beat and compares each rsp beat against the oldest
// predicted pixel.
// ----------------------------------------------------------------------------
module blpg_pixel_checker #(
   parameter int REQ_BITS = ((4*blpg_pkg::COORD_BITS+blpg_pkg::COLOR_BITS+7)/8)*8,
   parameter int RSP_BITS =
      ((2*blpg_pkg::COORD_BITS+blpg_pkg::OFFSET_BITS+blpg_pkg::COLOR_BITS+8)/8)*8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [REQ_BITS-1:0]                req_tdata,
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [RSP_BITS-1:0]                rsp_tdata,
   input  logic                               rsp_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [blpg_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [blpg_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                               csr_pready,
   output int                                 mismatch_count,
   output int                                 pending_count,
   output int                                 pixels_checked
);

   localparam int CB      = blpg_pkg::COORD_BITS;
   localparam int OB      = blpg_pkg::OFFSET_BITS;
   localparam int KB      = blpg_pkg::COLOR_BITS;
   localparam int PY_LSB  = CB;
   localparam int INF_BIT = 2*CB;
   localparam int OFF_LSB = 2*CB + 1;
   localparam int COL_LSB = OFF_LSB + OB;
   localparam int PAD_LSB = COL_LSB + KB;
   localparam int MAX_PRINTED = 40;

   typedef struct {
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      logic          in_frame;
      logic [OB-1:0] offset;
      logic [KB-1:0] color;
      logic          is_last;
   } pixel_type;

   pixel_type expected_pixels[$];

   blpg_pkg::cfg_type     frame_cfg;
   int                    cur_x, cur_y, final_x, final_y;
   int                    error_term, major_len, minor_len, step_x, step_y;
   int                    steps_left;
   bit                    y_major, line_active;
   logic [KB-1:0]         line_color;

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("[%0t] pixel %0d: %s got 0x%0h, expected 0x%0h",
                  $realtime, pixels_checked, what, got, want);
      end
   endtask

   function automatic int as_coord(logic [CB-1:0] v);
      return int'($signed(v));
   endfunction

   // Clip against the frame and form the byte address; out of frame gives 0.
   function automatic pixel_type make_pixel(int x, int y, bit is_last);
      pixel_type p;
      bit        in_view;
      longint    sum;
      in_view = x >= 0 && y >= 0 && x < int'(frame_cfg.frame_width) &&
                y < int'(frame_cfg.frame_height);
      sum = longint'(y) * longint'(frame_cfg.line_stride) +
            longint'(x) * longint'(frame_cfg.bytes_per_pixel);
      p.x        = x[CB-1:0];
      p.y        = y[CB-1:0];
      p.in_frame = in_view;
      p.offset   = in_view ? sum[OB-1:0] : '0;
      p.color    = line_color;
      p.is_last  = is_last;
      return p;
   endfunction

   task automatic start_line(logic [REQ_BITS-1:0] d);
      int x1, y1, x2, y2, dx, dy;
      x1 = as_coord(d[0 +: CB]);
      y1 = as_coord(d[CB +: CB]);
      x2 = as_coord(d[2*CB +: CB]);
      y2 = as_coord(d[3*CB +: CB]);
      dx = x2 - x1;
      dy = y2 - y1;
      step_x = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      step_y = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      y_major     = dy > dx;
      major_len   = y_major ? dy : dx;
      minor_len   = y_major ? dx : dy;
      error_term  = 2*minor_len - major_len;
      steps_left  = major_len;
      cur_x       = x1;
      cur_y       = y1;
      final_x     = x2;
      final_y     = y2;
      line_color  = d[4*CB +: KB];
      line_active = 1'b1;
   endtask

   task automatic advance_line();
      if (!line_active) return;
      if (steps_left == 0) begin
         expected_pixels.push_back(make_pixel(final_x, final_y, 1'b1));
         line_active = 1'b0;
      end else begin
         expected_pixels.push_back(make_pixel(cur_x, cur_y, 1'b0));
         if (error_term >= 0) begin
            error_term -= 2*major_len;
            if (y_major) cur_x += step_x;
            else cur_y += step_y;
         end
         error_term += 2*minor_len;
         if (y_major) cur_y += step_y;
         else cur_x += step_x;
         steps_left--;
      end
   endtask

   task automatic check_pixel();
      pixel_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch("beat with no pixel expected", rsp_tdata[63:0], '0);
         return;
      end
      want = expected_pixels.pop_front();
      if (rsp_tdata[0 +: CB] !== want.x)
         report_mismatch("pixel_x", 64'(rsp_tdata[0 +: CB]), 64'(want.x));
      if (rsp_tdata[PY_LSB +: CB] !== want.y)
         report_mismatch("pixel_y", 64'(rsp_tdata[PY_LSB +: CB]), 64'(want.y));
      if (rsp_tdata[INF_BIT] !== want.in_frame)
         report_mismatch("in_frame", 64'(rsp_tdata[INF_BIT]), 64'(want.in_frame));
      if (rsp_tdata[OFF_LSB +: OB] !== want.offset)
         report_mismatch("byte_offset", 64'(rsp_tdata[OFF_LSB +: OB]), 64'(want.offset));
      if (rsp_tdata[COL_LSB +: KB] !== want.color)
         report_mismatch("pixel_color", 64'(rsp_tdata[COL_LSB +: KB]), 64'(want.color));
      if (rsp_tdata[RSP_BITS-1:PAD_LSB] !== '0)
         report_mismatch("tdata padding", 64'(rsp_tdata[RSP_BITS-1:PAD_LSB]), '0);
      if (rsp_tlast !== want.is_last)
         report_mismatch("last", 64'(rsp_tlast), 64'(want.is_last));
      pixels_checked++;
   endtask

   task automatic write_register();
      case (blpg_pkg::csr_reg_type'(csr_paddr[3:2]))
         blpg_pkg::REG_FRAME_WIDTH:
            frame_cfg.frame_width = csr_pwdata[blpg_pkg::DIM_BITS-1:0];
         blpg_pkg::REG_FRAME_HEIGHT:
            frame_cfg.frame_height = csr_pwdata[blpg_pkg::DIM_BITS-1:0];
         blpg_pkg::REG_LINE_STRIDE:
            frame_cfg.line_stride = csr_pwdata[blpg_pkg::STRIDE_BITS-1:0];
         blpg_pkg::REG_BYTES_PER_PIXEL:
            frame_cfg.bytes_per_pixel = csr_pwdata[blpg_pkg::BPP_BITS-1:0];
         default: ;
      endcase
   endtask

   // Results are compared before the req beat of the same edge is predicted;
   // a pixel never leaves the pipeline in the cycle its step beat is taken.
   always @(posedge clock) begin
      if (reset) begin
         frame_cfg   = {blpg_pkg::FRAME_WIDTH_RESET, blpg_pkg::FRAME_HEIGHT_RESET,
                        blpg_pkg::LINE_STRIDE_RESET, blpg_pkg::BYTES_PER_PIXEL_RESET};
         cur_x       = 0;
         cur_y       = 0;
         final_x     = 0;
         final_y     = 0;
         error_term  = 0;
         major_len   = 0;
         minor_len   = 0;
         step_x      = 0;
         step_y      = 0;
         steps_left  = 0;
         y_major     = 1'b0;
         line_active = 1'b0;
         line_color  = '0;
         expected_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_pixel();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) write_register();
         if (req_tvalid && req_tready) begin
            if (req_tuser == blpg_pkg::MODE_START) start_line(req_tdata);
            else advance_line();
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

// File: sim/tb_bresenham_line_pixel_generator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_pixel_generator_unit: line rasterizer testbench
// Drives start and step beats under random back-pressure on both channels,
// changes the frame registers between phases and leaves all checking to the
// pixel scoreboard, whose mismatch and pending counts decide the verdict.
// ----------------------------------------------------------------------------
module tb_bresenham_line_pixel_generator_unit;

   localparam int CB       = blpg_pkg::COORD_BITS;
   localparam int KB       = blpg_pkg::COLOR_BITS;
   localparam int REQ_BITS = ((4*CB+KB+7)/8)*8;
   localparam int RSP_BITS = ((2*CB+blpg_pkg::OFFSET_BITS+KB+8)/8)*8;

   localparam int RESET_CYCLES     = 7;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int PHASE_ITEMS      = 205;
   // A pixel is two stages deep; spare cycles follow the last pixel before
   // the frame registers change.
   localparam int SETTLE_CYCLES    = 6;
   // Once this many pixels have been taken, the consumer stops for a long
   // stretch so that both stages fill and req_tready drops.
   localparam int LONG_HOLD_AFTER  = 300;
   localparam int LONG_HOLD_CYCLES = 400;

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic [REQ_BITS-1:0]                req_tdata   = '0;
   logic                               req_tuser   = blpg_pkg::MODE_START;
   logic                               req_tvalid  = 1'b0;
   logic                               req_tready;
   logic [RSP_BITS-1:0]                rsp_tdata;
   logic                               rsp_tlast;
   logic                               rsp_tvalid;
   logic                               rsp_tready  = 1'b0;
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [blpg_pkg::CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [blpg_pkg::CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [blpg_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   int mismatch_count;
   int pending_count;
   int pixels_checked;

   // Stimulus bookkeeping: how many step beats the current line still needs
   // to reach its endpoint, so a phase can close the line before the
   // registers change.
   int steps_to_end  = 0;
   int lines_started = 0;
   int settings_used = 1;
   int sender_calm   = 0;
   int cycles_run    = 0;

   bresenham_line_pixel_generator_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   blpg_pixel_checker pixel_check (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .pixels_checked (pixels_checked)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog: a run that hangs or loses pixels ends here as a failure.
   initial begin : watchdog
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Idle gap length shared by both sides: mostly none, often a few cycles,
   // now and then a long one.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // Consumer side of the rsp channel. It stalls at random, sometimes runs
   // for a calm stretch with rsp_tready held high, and once holds off for a
   // long time while the producer keeps offering beats.
   initial begin : rsp_consumer
      int stall_left;
      int calm_left;
      int taken;
      bit long_hold_done;
      stall_left     = 0;
      calm_left      = 0;
      taken          = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) taken++;
         if (!long_hold_done && taken >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else begin
               stall_left = gap_length();
               if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 150);
            end
         end
      end
   end

   // One beat on the req channel. Called at a rising edge; returns at the
   // edge where the beat was taken, leaving req_tvalid high so back-to-back
   // beats follow without a gap.
   task automatic send_beat(input blpg_pkg::mode_type kind,
                            input logic [REQ_BITS-1:0] data);
      int gap;
      if (sender_calm > 0) begin
         sender_calm--;
         gap = 0;
      end else begin
         gap = gap_length();
         if ($urandom_range(0, 199) == 0) sender_calm = $urandom_range(50, 150);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic start_line(input int x1, input int y1, input int x2, input int y2,
                             input logic [KB-1:0] color);
      logic [REQ_BITS-1:0] data;
      int                  dx, dy;
      data = '0;
      data[0 +: CB]    = x1[CB-1:0];
      data[CB +: CB]   = y1[CB-1:0];
      data[2*CB +: CB] = x2[CB-1:0];
      data[3*CB +: CB] = y2[CB-1:0];
      data[4*CB +: KB] = color;
      dx = (x2 > x1) ? x2 - x1 : x1 - x2;
      dy = (y2 > y1) ? y2 - y1 : y1 - y2;
      steps_to_end = ((dx > dy) ? dx : dy) + 1;
      lines_started++;
      send_beat(blpg_pkg::MODE_START, data);
   endtask

   // Step beats carry random payload, which the block must ignore.
   task automatic step_line(input int count);
      repeat (count) begin
         send_beat(blpg_pkg::MODE_STEP, REQ_BITS'({$urandom, $urandom, $urandom}));
         if (steps_to_end > 0) steps_to_end--;
      end
   endtask

   task automatic csr_write(input blpg_pkg::csr_reg_type index,
                            input logic [blpg_pkg::CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_frame(input int width, input int height, input int stride,
                                  input int bpp);
      csr_write(blpg_pkg::REG_FRAME_WIDTH, width);
      csr_write(blpg_pkg::REG_FRAME_HEIGHT, height);
      csr_write(blpg_pkg::REG_LINE_STRIDE, stride);
      csr_write(blpg_pkg::REG_BYTES_PER_PIXEL, bpp);
      settings_used++;
   endtask

   // Close the current line, stop offering beats and wait until every
   // predicted pixel has come back, so the block is idle for a register
   // write.
   task automatic end_phase();
      if (steps_to_end > 0) step_line(steps_to_end);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Start points cluster near the frame origin so that many pixels land
   // in frame; the rest spread over the whole signed coordinate range.
   function automatic int pick_coord();
      logic [31:0]   bits;
      logic [CB-1:0] raw;
      bits = $urandom;
      raw  = bits[CB-1:0];
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 400);
      return int'($signed(raw));
   endfunction

   function automatic int pick_end(input int from);
      int span;
      int dest;
      span = 12;
      if ($urandom_range(0, 9) >= 8) span = 80;
      if ($urandom_range(0, 149) == 0) span = 300;
      dest = from + int'($urandom_range(0, 2*span)) - span;
      if (dest > 2047) dest = 2047;
      if (dest < -2048) dest = -2048;
      return dest;
   endfunction

   // Mostly whole lines with random endpoints and colors, some with a few
   // extra steps past the endpoint, some abandoned part way by the next
   // start, and a little noise of lone step beats.
   task automatic run_random_phase(input int budget);
      int done;
      int roll;
      int x1, y1, x2, y2;
      int count;
      done = 0;
      while (done < budget) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            step_line(1);
         end else begin
            x1 = pick_coord();
            y1 = pick_coord();
            x2 = pick_end(x1);
            y2 = pick_end(y1);
            start_line(x1, y1, x2, y2, $urandom);
            count = steps_to_end;
            if (roll < 70) begin
               count = steps_to_end;
            end else if (roll < 85) begin
               count = steps_to_end + $urandom_range(1, 3);
            end else begin
               count = $urandom_range(0, steps_to_end - 1);
            end
            step_line(count);
            done += count + 1;
         end
      end
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, under the reset frame settings.
      // A step with no line active must give nothing.
      step_line(1);
      // Equal endpoints: the first step is the endpoint itself, with last.
      start_line(0, 0, 0, 0, 32'hFFFF_FFFF);
      step_line(2);
      // Full-range diagonal from the most negative corner, all out of frame,
      // then dropped by the next start.
      start_line(-2048, -2048, 2047, 2047, 32'h0000_0000);
      step_line(3);
      // The longest x-major line, right to left, abandoned after two pixels.
      start_line(2047, 2047, -2048, 2040, 32'hA5A5_5A5A);
      step_line(2);
      // Steep line with y as the major axis, run through to its endpoint.
      start_line(3, 1, 7, 9, 32'h1234_5678);
      step_line(9);
      // Last in-frame pixel at the bottom right, then one just past the edge.
      start_line(1023, 767, 1024, 766, 32'h8000_0001);
      step_line(2);

      run_random_phase(PHASE_ITEMS);
      end_phase();

      // Empty frame: nothing is in frame; largest stride and pixel size.
      configure_frame(0, 0, 16383, 7);
      run_random_phase(PHASE_ITEMS);
      end_phase();

      // Largest frame, with the largest stride and pixel size.
      configure_frame(4095, 4095, 16383, 7);
      run_random_phase(PHASE_ITEMS);
      end_phase();

      configure_frame(320, 240, 640, 2);
      run_random_phase(PHASE_ITEMS);
      end_phase();

      // Zero stride and zero pixel size: every in-frame offset is zero.
      configure_frame(2048, 2048, 0, 0);
      run_random_phase(PHASE_ITEMS);
      end_phase();

      configure_frame($urandom_range(1, 2048), $urandom_range(1, 2048),
                      $urandom_range(0, 16383), $urandom_range(1, 4));
      run_random_phase(PHASE_ITEMS);
      end_phase();

      // One-pixel frame: only the origin is in frame.
      configure_frame(1, 1, 1, 1);
      run_random_phase(PHASE_ITEMS);
      end_phase();

      $display("Run covered %0d lines and %0d compared pixels over %0d frame settings,",
               lines_started, pixels_checked, settings_used);
      $display("with random stalls on both channels and one long consumer hold-off.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
